>>> rtl/core/dae_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the delete-and-earn block.
// No dependencies; used by dae_ctrl, dae_dp and the top level.
package dae_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int SCORE_W     = 32;
  localparam int VAL_W       = 10;
  localparam int OUT_W       = 32;
  localparam int ADDR_W      = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;     // clearing pass: zero mem[idx]
    logic accept;     // take a word, read its bucket
    logic load_wr;    // write back bucket + value
    logic walk_init;  // zero the recurrence registers
    logic walk_rd;    // read mem[idx] for the walk
    logic idx_clr;    // return idx to zero
    logic emit;       // register the result and strobe it
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_at_top;
    logic idx_at_largest;
    logic last_r;
  } dp_sts_t;

  function automatic score_t sat_add(score_t a, score_t b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
  endfunction

  function automatic logic in_range(logic [VAL_W-1:0] v);
    logic [32+VAL_W-1:0] w;
    w = {32'd0, v};
    return w < (32+VAL_W)'(VALUE_RANGE);
  endfunction

  function automatic addr_t to_addr(logic [VAL_W-1:0] v);
    logic [ADDR_W+VAL_W-1:0] w;
    w = {{ADDR_W{1'b0}}, v};
    return w[ADDR_W-1:0];
  endfunction

  function automatic score_t val_to_score(logic [VAL_W-1:0] v);
    logic [SCORE_W+VAL_W-1:0] w;
    w = {{SCORE_W{1'b0}}, v};
    return w[SCORE_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(score_t s);
    logic [OUT_W+SCORE_W-1:0] w;
    w = {{OUT_W{1'b0}}, s};
    return (w[OUT_W+SCORE_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/core/delete_and_earn_max_points.sv
`timescale 1ns / 1ps
// Delete-and-earn maximum points over value buckets (house-robber recurrence).
// Input: a word (value, last) is taken on a rising edge with start high and
//   busy low. Each word adds its value into a point bucket and tracks the
//   largest value seen in the set.
// Output: one word per set, best_total, valid for exactly one cycle while done
//   is high; the receiver cannot stall it.
// A non-last word reads its bucket, then writes it back with busy high. A last
//   word then walks buckets 0 to largest and drains; done rises in the cycle
//   after the drain, with busy going low. The walk reads one bucket a cycle from
//   the single-read-port point memory, zeroing it behind itself for the next set.
// Reset: rst is synchronous. After it the block runs a clearing pass over the
//   whole point memory, all VALUE_RANGE (1024) entries, with busy high.
// Sums saturate at all ones; best_total saturates at 32 bits.
// Depends on dae_pkg, dae_ctrl, dae_dp.
module delete_and_earn_max_points (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [dae_pkg::VAL_W-1:0] value,
  input  logic                      last,
  output logic                      done,
  output logic [dae_pkg::OUT_W-1:0] best_total
);

  dae_pkg::dp_cmd_t cmd;
  dae_pkg::dp_sts_t sts;

  dae_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dae_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .last       (last),
    .best_total (best_total),
    .done       (done)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

endmodule

>>> rtl/core/dae_dp.sv
`timescale 1ns / 1ps
// Datapath: point memory, walk counter, largest value and the max recurrence.
// Depends on dae_pkg; driven by dae_ctrl through dp_cmd_t.
module dae_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  dae_pkg::dp_cmd_t         cmd,
  output dae_pkg::dp_sts_t         sts,
  input  logic [dae_pkg::VAL_W-1:0] value,
  input  logic                     last,
  output logic [dae_pkg::OUT_W-1:0] best_total,
  output logic                     done
);

  dae_pkg::score_t mem [dae_pkg::VALUE_RANGE];
  dae_pkg::score_t rd_data;
  dae_pkg::addr_t  rd_addr;
  dae_pkg::addr_t  rd_sel;
  dae_pkg::addr_t  in_addr;
  dae_pkg::addr_t  val_addr;
  dae_pkg::addr_t  idx;
  dae_pkg::addr_t  largest;
  logic [dae_pkg::VAL_W-1:0] val_r;
  logic            in_rng;
  logic            last_r;
  logic            rd_pend;
  dae_pkg::score_t best_prev;
  dae_pkg::score_t best_pp;
  dae_pkg::score_t load_sum;
  dae_pkg::score_t take;
  dae_pkg::score_t cur;

  assign in_addr  = dae_pkg::to_addr(value);
  assign val_addr = dae_pkg::to_addr(val_r);
  assign rd_sel   = cmd.accept ? in_addr : idx;
  assign load_sum = dae_pkg::sat_add(rd_data, dae_pkg::val_to_score(val_r));
  assign take     = dae_pkg::sat_add(best_pp, rd_data);
  assign cur      = (take > best_prev) ? take : best_prev;

  assign sts.idx_at_top     = (idx == dae_pkg::ADDR_W'(dae_pkg::VALUE_RANGE - 1));
  assign sts.idx_at_largest = (idx == largest);
  assign sts.last_r         = last_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[idx] <= '0;
    end else if (cmd.load_wr && in_rng) begin
      mem[val_addr] <= load_sum;
    end else if (rd_pend) begin
      mem[rd_addr] <= '0;
    end
    if (cmd.accept || cmd.walk_rd) begin
      rd_data <= mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= value;
      in_rng <= dae_pkg::in_range(value);
    end
    if (cmd.walk_rd) begin
      rd_addr <= idx;
    end
    if (cmd.emit) begin
      best_total <= dae_pkg::to_out(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      largest   <= '0;
      last_r    <= 1'b0;
      rd_pend   <= 1'b0;
      best_prev <= '0;
      best_pp   <= '0;
      done      <= 1'b0;
    end else begin
      rd_pend <= cmd.walk_rd;
      done    <= cmd.emit;
      if (cmd.accept) begin
        last_r <= last;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.clr_wr || cmd.walk_rd) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit) begin
        largest <= '0;
      end else if (cmd.load_wr && in_rng && (val_addr > largest)) begin
        largest <= val_addr;
      end
      if (cmd.walk_init || cmd.emit) begin
        best_prev <= '0;
        best_pp   <= '0;
      end else if (rd_pend) begin
        best_pp   <= best_prev;
        best_prev <= cur;
      end
    end
  end

endmodule

>>> rtl/core/dae_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences clearing pass, load read-modify-write, walk and emit.
// Depends on dae_pkg; commands dae_dp through dp_cmd_t.
module dae_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dae_pkg::dp_sts_t sts,
  output dae_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_at_top) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        if (sts.last_r) begin
          cmd.walk_init = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.idx_at_largest) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_LOAD))
    else $error("accepted word did not enter load");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && sts.idx_at_largest) |=> (state == ST_DRAIN))
    else $error("walk did not stop at largest value");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && sts.idx_at_top) |=> (state == ST_IDLE))
    else $error("clearing pass overran");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for delete_and_earn_max_points: value sets go in as bursts of words.
// A bucket scoreboard predicts best_total per set. Depends on dae_pkg and the RTL top.
module testbench;

  localparam int unsigned QUIET_LIMIT = 5000;  // longer than a clearing pass or a full walk
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam int unsigned WORD_GOAL   = 1950;

  class points_scoreboard;
    dae_pkg::score_t           bucket [dae_pkg::VALUE_RANGE];
    int unsigned               top_value;
    logic [dae_pkg::OUT_W-1:0] totals_due [$];
    int unsigned               failures;

    function new();
      foreach (bucket[i]) bucket[i] = '0;
      top_value = 0;
      failures  = 0;
    endfunction

    function dae_pkg::score_t clip_add(dae_pkg::score_t a, dae_pkg::score_t b);
      dae_pkg::score_t s;
      s = a + b;
      if (s < a) s = '1;
      return s;
    endfunction

    function void queue_total(logic [dae_pkg::OUT_W-1:0] t);
      totals_due = {totals_due, t};
    endfunction

    // Accepted input word: bucket it, and on the last word run the robber walk.
    function void add_word(logic [dae_pkg::VAL_W-1:0] v, logic fin);
      dae_pkg::score_t keep, prior, take, best;
      int unsigned     idx;
      if (int'(v) < dae_pkg::VALUE_RANGE) begin
        bucket[v] = clip_add(bucket[v], dae_pkg::score_t'(v));
        if (int'(v) > top_value) top_value = 32'(v);
      end
      if (!fin) return;
      keep  = '0;  // best through idx-1
      prior = '0;  // best through idx-2
      for (idx = 0; idx <= top_value && idx < dae_pkg::VALUE_RANGE; idx++) begin
        take = clip_add(prior, bucket[idx]);
        best = (take > keep) ? take : keep;
        bucket[idx] = '0;
        prior = keep;
        keep  = best;
      end
      top_value = 0;
      if ((keep >> dae_pkg::OUT_W) != 0) queue_total('1);
      else queue_total(dae_pkg::OUT_W'(keep));
    endfunction

    function void check_total(logic [dae_pkg::OUT_W-1:0] got);
      logic [dae_pkg::OUT_W-1:0] want;
      if (totals_due.size() == 0) begin
        if (failures < 10) $display("unexpected best_total %0d, nothing pending", got);
        failures++;
        return;
      end
      want = totals_due.pop_front();
      if (got !== want) begin
        if (failures < 10) $display("best_total mismatch: expected %0d, got %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  logic                      clk   = 1'b0;
  logic                      rst   = 1'b1;
  logic                      start = 1'b0;
  logic [dae_pkg::VAL_W-1:0] value = '0;
  logic                      last  = 1'b0;
  logic                      busy;
  logic                      done;
  logic [dae_pkg::OUT_W-1:0] best_total;

  points_scoreboard totals_sb;
  int unsigned      words_sent  = 0;
  int unsigned      burst_left  = 0;
  int unsigned      quiet_cycles = 0;

  always #10 clk = ~clk;

  delete_and_earn_max_points u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .last       (last),
    .done       (done),
    .best_total (best_total)
  );

  always @(posedge clk) begin
    if (!rst && done) totals_sb.check_total(best_total);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [dae_pkg::VAL_W-1:0] v, input logic fin);
    start <= 1'b1;
    value <= v;
    last  <= fin;
    do @(posedge clk); while (busy);
    totals_sb.add_word(v, fin);
    words_sent++;
  endtask

  // Sender idles between bursts; junk on the data lines while start is low.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    start <= 1'b0;
    repeat (gap) begin
      value <= dae_pkg::VAL_W'($urandom);
      last  <= 1'($urandom);
      @(posedge clk);
    end
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
  endtask

  initial begin
    logic [dae_pkg::VAL_W-1:0] seed_vals [22];
    logic                      seed_ends [22];
    logic [dae_pkg::VAL_W-1:0] v;
    int unsigned               k, len, lo, hi, mode;

    // singles at both ends, a run, duplicates, the top pair, zeros mixed in, bit patterns
    seed_vals = '{0, 1023, 1, 2, 3, 2, 2, 3, 3, 3, 4, 1022, 1023, 0, 1023,
                  5, 0, 5, 7, 512, 341, 682};
    seed_ends = '{1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1,
                  0, 0, 0, 1, 1, 1, 1};
    totals_sb = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (seed_vals[i]) send_word(seed_vals[i], seed_ends[i]);

    while (words_sent < WORD_GOAL) begin
      mode = $urandom_range(0, 9);
      lo = 0;
      if (mode < 6) hi = 15;
      else if (mode < 8) hi = 127;
      else if (mode == 8) hi = dae_pkg::VALUE_RANGE - 1;
      else begin
        lo = dae_pkg::VALUE_RANGE - 128;
        hi = dae_pkg::VALUE_RANGE - 1;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (k = 1; k <= len; k++) begin
        v = dae_pkg::VAL_W'($urandom_range(lo, hi));
        if (hi == dae_pkg::VALUE_RANGE - 1 && $urandom_range(0, 7) == 0) begin
          v = dae_pkg::VAL_W'(dae_pkg::VALUE_RANGE - 1);
        end
        pace_sender();
        send_word(v, k == len);
      end
    end
    start <= 1'b0;

    while (totals_sb.totals_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (totals_sb.failures == 0 && totals_sb.totals_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dae_pkg.sv
rtl/core/dae_dp.sv
rtl/core/dae_ctrl.sv
rtl/core/delete_and_earn_max_points.sv
bench/testbench.sv
